### rtl/core/fsd_pkg.sv
package fsd_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned FluxW   = 20;
  localparam int unsigned FillW   = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CountW  = 28;
  localparam int unsigned AccW    = 29;
  localparam int unsigned CfgIdxW = 2;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_FLUX = 2'd0;
  localparam logic [KindW-1:0] KIND_FILL = 2'd1;
  localparam logic [KindW-1:0] KIND_END  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_MIN_FLUX    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_FLUX    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FILL_PERIOD = 2'd2;

  localparam logic [FluxW-1:0] MIN_FLUX_RST    = 20'd57;
  localparam logic [FluxW-1:0] MAX_FLUX_RST    = 20'd10800;
  localparam logic [FillW-1:0] FILL_PERIOD_RST = 16'd90;

  // Lead byte codes.
  localparam logic [CodeW-1:0] CODE_END        = 8'd0;
  localparam logic [CodeW-1:0] CODE_SHORT_LEAD = 8'd250;
  localparam logic [CodeW-1:0] CODE_LONG_LEAD  = 8'd255;
  localparam logic [CodeW-1:0] SHORT_OFFSET    = 8'd249;
  localparam int unsigned      ShortScale      = 250;
  localparam int unsigned      LongBytes       = 4;

  // One quotient bit per divider step.
  localparam int unsigned DivSteps = AccW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic step;       // transfer of one input byte
    logic div_step;   // one restoring-division iteration
    logic push_fill;  // load the fill result into the output register
  } fsd_cmd_t;

  typedef struct packed {
    logic need_div;   // the byte on the input yields a fill run
    logic div_last;   // divider is on its final iteration
    logic slot_free;  // output register can take a result this cycle
  } fsd_sts_t;

endpackage

### rtl/core/fsd_ctrl.sv
module fsd_ctrl import fsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fsd_sts_t sts,
  output fsd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && sts.slot_free;

  always_comb begin
    state_nxt     = state_r;
    cmd.step      = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.push_fill = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.step = 1'b1;
          if (sts.need_div) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.slot_free) begin
          cmd.push_fill = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/fsd_dp.sv
module fsd_dp import fsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CodeW-1:0]     in_code_byte,
  input  logic                 cfg_valid,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [FluxW-1:0]     cfg_data,
  input  fsd_cmd_t             cmd,
  output fsd_sts_t             sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KindW-1:0]     out_kind,
  output logic [FluxW-1:0]     out_period_minus_one,
  output logic [AccW-1:0]      out_repeat_count
);

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_SHORT = 2'd1;
  localparam logic [1:0] PH_LONG  = 2'd2;

  logic [FluxW-1:0]  min_flux_r, max_flux_r;
  logic [FillW-1:0]  fill_period_r;

  logic [1:0]        phase_r, phase_nxt;
  logic [2:0]        left_r, left_nxt;
  logic [CountW-1:0] part_r, part_nxt;
  logic [AccW-1:0]   acc_r;

  logic [FillW-1:0]  div_fp_r;
  logic [FillW-1:0]  rem_r;
  logic [AccW-1:0]   quo_r;
  logic [DivCntW-1:0] div_cnt_r;

  logic              out_valid_r;
  logic [KindW-1:0]  kind_r;
  logic [FluxW-1:0]  period_r;
  logic [AccW-1:0]   repeat_r;

  logic              have, is_end;
  logic [CountW-1:0] count;
  logic [1:0]        k;
  logic [2:0]        lead_mult;
  logic [CountW-1:0] long_bits;
  logic [AccW-1:0]   acc_sum;
  logic              below_min, above_max;
  logic              emit_flux;
  logic [FillW:0]    trial;
  logic              trial_ge;

  // Byte parser: decides whether this byte completes a tick count.
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    part_nxt  = part_r;
    have      = 1'b0;
    is_end    = 1'b0;
    count     = '0;
    k         = 2'(3'(LongBytes) - left_r);
    lead_mult = 3'(in_code_byte - SHORT_OFFSET);
    long_bits = CountW'(in_code_byte[CodeW-1:1]) << (5'(k) * 5'd7);
    case (phase_r)
      PH_SHORT: begin
        count     = part_r + CountW'(in_code_byte) - CountW'(1);
        phase_nxt = PH_LEAD;
        part_nxt  = '0;
        have      = 1'b1;
      end
      PH_LONG: begin
        part_nxt = part_r | long_bits;
        left_nxt = left_r - 3'd1;
        if (left_nxt == 3'd0) begin
          count     = part_nxt;
          phase_nxt = PH_LEAD;
          part_nxt  = '0;
          have      = 1'b1;
        end
      end
      default: begin
        if (in_code_byte == CODE_END) begin
          is_end = 1'b1;
        end else if (in_code_byte < CODE_SHORT_LEAD) begin
          count = CountW'(in_code_byte);
          have  = 1'b1;
        end else if (in_code_byte < CODE_LONG_LEAD) begin
          part_nxt  = CountW'(lead_mult) * CountW'(ShortScale);
          phase_nxt = PH_SHORT;
        end else begin
          part_nxt  = '0;
          left_nxt  = 3'(LongBytes);
          phase_nxt = PH_LONG;
        end
      end
    endcase
  end

  assign acc_sum   = acc_r + AccW'(count);
  assign below_min = (acc_sum == '0) || (acc_sum < AccW'(min_flux_r));
  assign above_max = acc_sum > AccW'(max_flux_r);
  assign emit_flux = have && !below_min && !above_max;

  // Restoring divider: remainder stays below the divisor.
  assign trial    = {rem_r, quo_r[AccW-1]};
  assign trial_ge = trial >= {1'b0, div_fp_r};

  assign sts.need_div  = have && !below_min && above_max;
  assign sts.div_last  = div_cnt_r == DivCntW'(DivSteps - 1);
  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_flux_r    <= MIN_FLUX_RST;
      max_flux_r    <= MAX_FLUX_RST;
      fill_period_r <= FILL_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_FLUX:    min_flux_r    <= cfg_data;
        REG_MAX_FLUX:    max_flux_r    <= cfg_data;
        REG_FILL_PERIOD: fill_period_r <= cfg_data[FillW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      left_r      <= '0;
      part_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.step) begin
        if (is_end) begin
          phase_r     <= PH_LEAD;
          left_r      <= '0;
          part_r      <= '0;
          acc_r       <= '0;
          out_valid_r <= 1'b1;
        end else begin
          phase_r <= phase_nxt;
          left_r  <= left_nxt;
          part_r  <= part_nxt;
          if (have) begin
            acc_r <= emit_flux ? '0 : acc_sum;
          end
          if (emit_flux) begin
            out_valid_r <= 1'b1;
          end
        end
      end
      if (cmd.push_fill) begin
        acc_r       <= AccW'(rem_r);
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      div_fp_r  <= (fill_period_r == '0) ? FillW'(1) : fill_period_r;
      quo_r     <= acc_sum;
      rem_r     <= '0;
      div_cnt_r <= '0;
      if (is_end) begin
        kind_r   <= KIND_END;
        period_r <= '0;
        repeat_r <= '0;
      end else begin
        kind_r   <= KIND_FLUX;
        period_r <= acc_sum[FluxW-1:0] - FluxW'(1);
        repeat_r <= AccW'(1);
      end
    end
    if (cmd.div_step) begin
      rem_r     <= trial_ge ? FillW'(trial - {1'b0, div_fp_r}) : trial[FillW-1:0];
      quo_r     <= {quo_r[AccW-2:0], trial_ge};
      div_cnt_r <= div_cnt_r + DivCntW'(1);
    end
    if (cmd.push_fill) begin
      kind_r   <= KIND_FILL;
      period_r <= FluxW'(div_fp_r - FillW'(1));
      repeat_r <= quo_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = kind_r;
  assign out_period_minus_one = period_r;
  assign out_repeat_count     = repeat_r;

endmodule

### rtl/core/flux_stream_decoder_top.sv
// Flux stream decoder: turns coded bytes into write-timer periods.
// Input channel (in_valid/in_ready/in_code_byte) takes one coded byte per
// transfer. Result channel (out_valid/out_ready/out_*) gives at most one
// result per byte: a flux period, a no-flux fill run, or end of stream.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; index 0 min_flux, 1 max_flux, 2 fill_period, index 3 is ignored.
// Write configuration only while the block is idle.
// A byte that yields a flux period or end of stream shows its result in the
// cycle after its transfer, and a new byte is taken every cycle while the
// output register is free or being emptied. A byte that yields a fill run
// starts a restoring divider that makes one quotient bit per cycle; then
// the quotient is loaded into the output register once it is free, and no
// byte is taken meanwhile.
// in_ready also needs the output register free or being emptied, so a
// stalled receiver holds off the input after one waiting result.
// Synchronous reset restores the register defaults, clears the parser and
// tick accumulator, and drops out_valid.
module flux_stream_decoder_top import fsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CodeW-1:0]     in_code_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KindW-1:0]     out_kind,
  output logic [FluxW-1:0]     out_period_minus_one,
  output logic [AccW-1:0]      out_repeat_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [FluxW-1:0]     cfg_data
);

  fsd_cmd_t cmd;
  fsd_sts_t sts;

  assign cfg_ready = 1'b1;

  fsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fsd_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_code_byte         (in_code_byte),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_period_minus_one (out_period_minus_one),
    .out_repeat_count     (out_repeat_count)
  );

endmodule
